/* sv/lsmt_pkg.sv */
// lsmt_pkg: sizes and constants shared by the linear sieve block
// no dependencies
package lsmt_pkg;

   localparam int MAX_LIMIT     = 65536;
   localparam int PRIME_DEPTH   = 8192;
   localparam int STORE_DEPTH   = MAX_LIMIT + 1;
   localparam int NUM_W         = 17;
   localparam int PHI_W         = 16;
   localparam int MU_W          = 2;
   localparam int MERT_W        = 10;
   localparam int STORE_AW      = $clog2(STORE_DEPTH);
   localparam int PRIME_AW      = $clog2(PRIME_DEPTH);
   localparam int COUNT_W       = $clog2(PRIME_DEPTH + 1);
   localparam int STORE_W       = 1 + MU_W + PHI_W;
   localparam int MUL_W         = NUM_W + PHI_W;

   localparam logic [NUM_W-1:0]  LIMIT_MAX   = NUM_W'(MAX_LIMIT);
   localparam logic [NUM_W-1:0]  NUM_SAT     = NUM_W'(MAX_LIMIT + 1);
   localparam logic [MERT_W:0]   MERT_HIGH   = (MERT_W+1)'(256);
   localparam logic [MERT_W:0]   MERT_LOW    = -(MERT_W+1)'(256);
   localparam logic [MU_W-1:0]   MU_ONE      = MU_W'(1);
   localparam logic [MU_W-1:0]   MU_MINUS    = MU_W'(-1);

endpackage

/* sv/lsmt_ram.sv */
// lsmt_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module lsmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/linear_sieve_mobius_totient.sv */
// linear_sieve_mobius_totient: incremental linear sieve with mobius, totient, mertens
// depends on lsmt_pkg and lsmt_ram
//
// Each item advances to the next integer (restart begins again at 1) and yields
// one result with primality, Mobius value, totient and the saturating Mertens sum.
// A sequencer drives one shared multiplier and a bit-serial remainder unit. For each
// listed prime whose multiple is marked, the marking walk does a prime read, a
// product, the remainder, a totient product, a mark write and the next check; the
// check is skipped for the prime that divides the integer, and the walk also ends
// on a product past the limit. It averages about one prime per integer. Past the
// limit an item goes from the store read straight to its result. Results wait for
// rsp_ready. After reset, and for an item with restart set, a clearing pass writes
// all 65537 mark entries, one per cycle, before the item proceeds; req_ready is low
// meanwhile.
module linear_sieve_mobius_totient
   import lsmt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_restart,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [NUM_W-1:0]         rsp_number,
   output logic                     rsp_in_range,
   output logic                     rsp_prime_flag,
   output logic signed [MU_W-1:0]   rsp_mobius_value,
   output logic [PHI_W-1:0]         rsp_totient_value,
   output logic signed [MERT_W-1:0] rsp_mertens_sum,
   input  logic                     csr_write_enable,
   input  logic [NUM_W-1:0]         csr_write_data
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_STEP, S_READ, S_EVAL, S_CHECK,
      S_PRIME, S_CMP, S_DIV, S_PHI, S_WR, S_OUT
   } state_type;

   state_type            state_ff;
   logic [NUM_W-1:0]     limit_ff;
   logic [NUM_W-1:0]     cur_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   k_ff;
   logic [STORE_AW-1:0]  clr_ff;
   logic                 pending_ff;
   logic [MU_W-1:0]      mu_ff;
   logic [PHI_W-1:0]     phi_ff;
   logic [PHI_W-1:0]     p_ff;
   logic [MUL_W-1:0]     mul_ff;
   logic [NUM_W-1:0]     addr_ff;
   logic [NUM_W-1:0]     rem_ff;
   logic [4:0]           bit_ff;
   logic [MERT_W-1:0]    mert_ff;
   logic                 in_range_ff;
   logic                 prime_ff;
   logic [PHI_W-1:0]     tot_out_ff;
   logic [MERT_W-1:0]    mert_out_ff;

   logic [NUM_W-1:0]     lim;
   logic [MUL_W-1:0]     mul_in;
   logic [NUM_W-1:0]     mul_a;
   logic [PHI_W-1:0]     mul_b;
   logic [NUM_W-1:0]     rem_shift;
   logic [NUM_W-1:0]     rem_in;
   logic                 divides;
   logic                 st_wr_en;
   logic [STORE_AW-1:0]  st_wr_addr;
   logic [STORE_W-1:0]   st_wr_data;
   logic [STORE_W-1:0]   st_rd_data;
   logic                 pl_wr_en;
   logic [PHI_W-1:0]     pl_rd_data;
   logic                 is_prime;
   logic [MU_W-1:0]      mu_in;
   logic [PHI_W-1:0]     phi_in;
   logic [MERT_W:0]      mert_sum;
   logic [MERT_W-1:0]    mert_in;

   assign lim = (limit_ff < LIMIT_MAX) ? limit_ff : LIMIT_MAX;

   // shared multiplier: i*p while walking, phi*(p or p-1) for the new totient
   assign divides = (rem_ff == '0);
   assign mul_a   = (state_ff == S_PRIME) ? cur_ff : {1'b0, phi_ff};
   assign mul_b   = (state_ff == S_PRIME) ? pl_rd_data : (divides ? p_ff : p_ff - 1'b1);
   assign mul_in  = MUL_W'(mul_a) * MUL_W'(mul_b);

   // one bit of restoring remainder per cycle
   assign rem_shift = {rem_ff[NUM_W-2:0], cur_ff[bit_ff]};
   assign rem_in    = (rem_shift >= {1'b0, p_ff}) ? rem_shift - {1'b0, p_ff} : rem_shift;

   // classify the current integer from its store entry
   always_comb begin
      is_prime = 1'b0;
      mu_in    = st_rd_data[STORE_W-2 -: MU_W];
      phi_in   = st_rd_data[PHI_W-1:0];
      if (cur_ff == NUM_W'(1)) begin
         mu_in  = MU_ONE;
         phi_in = PHI_W'(1);
      end else if (!st_rd_data[STORE_W-1]) begin
         is_prime = 1'b1;
         mu_in    = MU_MINUS;
         phi_in   = PHI_W'(cur_ff - 1'b1);
      end
      mert_sum = {mert_ff[MERT_W-1], mert_ff} + {{(MERT_W-1){mu_in[MU_W-1]}}, mu_in};
      if ($signed(mert_sum) > $signed(MERT_HIGH)) begin
         mert_in = MERT_HIGH[MERT_W-1:0];
      end else if ($signed(mert_sum) < $signed(MERT_LOW)) begin
         mert_in = MERT_LOW[MERT_W-1:0];
      end else begin
         mert_in = mert_sum[MERT_W-1:0];
      end
   end

   assign st_wr_en   = (state_ff == S_CLEAR) || (state_ff == S_WR);
   assign st_wr_addr = (state_ff == S_CLEAR) ? clr_ff : addr_ff;
   assign st_wr_data = (state_ff == S_CLEAR) ? '0 :
                       {1'b1, (divides ? MU_W'(0) : MU_W'(-mu_ff)), mul_ff[PHI_W-1:0]};
   assign pl_wr_en   = (state_ff == S_EVAL) && is_prime && (count_ff < COUNT_W'(PRIME_DEPTH));

   lsmt_ram #(.WIDTH(STORE_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (cur_ff),
      .rd_data (st_rd_data)
   );

   lsmt_ram #(.WIDTH(PHI_W), .DEPTH(PRIME_DEPTH)) u_primes (
      .clock   (clock),
      .wr_en   (pl_wr_en),
      .wr_addr (count_ff[PRIME_AW-1:0]),
      .wr_data (cur_ff[PHI_W-1:0]),
      .rd_addr (k_ff[PRIME_AW-1:0]),
      .rd_data (pl_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         limit_ff    <= LIMIT_MAX;
         cur_ff      <= '0;
         count_ff    <= '0;
         k_ff        <= '0;
         clr_ff      <= '0;
         pending_ff  <= 1'b0;
         mert_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == STORE_AW'(STORE_DEPTH - 1)) begin
                  state_ff <= pending_ff ? S_STEP : S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  if (req_restart) begin
                     cur_ff     <= '0;
                     count_ff   <= '0;
                     mert_ff    <= '0;
                     clr_ff     <= '0;
                     pending_ff <= 1'b1;
                     state_ff   <= S_CLEAR;
                  end else begin
                     state_ff <= S_STEP;
                  end
               end
            end
            S_STEP: begin
               pending_ff <= 1'b0;
               if (cur_ff < NUM_SAT) begin
                  cur_ff <= cur_ff + 1'b1;
               end
               state_ff <= S_READ;
            end
            S_READ: begin
               if (cur_ff > lim) begin
                  in_range_ff <= 1'b0;
                  prime_ff    <= 1'b0;
                  mu_ff       <= '0;
                  tot_out_ff  <= '0;
                  mert_out_ff <= '0;
                  state_ff    <= S_OUT;
               end else begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               in_range_ff <= 1'b1;
               prime_ff    <= is_prime;
               mu_ff       <= mu_in;
               phi_ff      <= phi_in;
               tot_out_ff  <= phi_in;
               mert_ff     <= mert_in;
               mert_out_ff <= mert_in;
               if (pl_wr_en) begin
                  count_ff <= count_ff + 1'b1;
               end
               k_ff     <= '0;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               state_ff <= (k_ff < count_ff) ? S_PRIME : S_OUT;
            end
            S_PRIME: begin
               p_ff     <= pl_rd_data;
               mul_ff   <= mul_in;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (mul_ff > {{PHI_W{1'b0}}, lim}) begin
                  state_ff <= S_OUT;
               end else begin
                  addr_ff  <= mul_ff[NUM_W-1:0];
                  rem_ff   <= '0;
                  bit_ff   <= 5'(NUM_W - 1);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= rem_in;
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == '0) begin
                  state_ff <= S_PHI;
               end
            end
            S_PHI: begin
               mul_ff   <= mul_in;
               state_ff <= S_WR;
            end
            S_WR: begin
               if (divides) begin
                  state_ff <= S_OUT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_CHECK;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = (state_ff == S_OUT);
   assign rsp_number        = cur_ff;
   assign rsp_in_range      = in_range_ff;
   assign rsp_prime_flag    = prime_ff;
   assign rsp_mobius_value  = in_range_ff ? mu_ff : '0;
   assign rsp_totient_value = tot_out_ff;
   assign rsp_mertens_sum   = mert_out_ff;

endmodule
